[src/abl_pkg.sv]
// Shared types and constants for the ambient brightness level tracker.
// Used by abl_mac and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package abl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ALPHA_W  = 16;
  localparam int BAND_W   = 7;
  localparam int TICKS_W  = 8;
  localparam int LEVEL_W  = 7;
  localparam int FILT_W   = 32;
  localparam int ACC_W    = 48;
  localparam int Q8_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd9830;
  localparam logic [BAND_W-1:0]  BAND_RESET  = 7'd2;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd16;

  // Mapping of the average onto levels: level = avg*99/1024 + 1, in Q.8.
  localparam logic [15:0]     LEVEL_SLOPE  = 16'd99;
  localparam logic [Q8_W-1:0] LEVEL_MIN_Q8 = 15'd256;
  localparam logic [Q8_W-1:0] LEVEL_MAX_Q8 = 15'd25600;
  localparam logic [TICKS_W-1:0] SETTLE_MAX = 8'd255;

  // Command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;     // update the accumulator this cycle
    logic clear;  // start a new sum instead of adding to the old one
    logic upper;  // weight the product by 2^16
  } mac_op_t;

endpackage
`default_nettype wire

[src/abl_mac.sv]
// Shared 16x16 multiply-accumulate unit with a 48-bit accumulator.
// Depends on abl_pkg for the command struct and widths.
`timescale 1ns / 1ps
`default_nettype none
module abl_mac (
  input  wire logic                    clk,
  input  wire abl_pkg::mac_op_t        op,
  input  wire logic [15:0]             x,
  input  wire logic [15:0]             y,
  output logic [abl_pkg::ACC_W-1:0]    acc
);
  import abl_pkg::*;

  logic [31:0]      prod;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] base;

  always_comb begin
    prod = x * y;
    term = op.upper ? {prod, 16'd0} : {16'd0, prod};
    base = op.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + term;
    end
  end

endmodule
`default_nettype wire

[src/ambient_brightness_level_tracker.sv]
// Top level of the ambient brightness level tracker: sequencer, state, hysteresis.
// Depends on abl_pkg and abl_mac.
//
//  channel   | dir | handshake         | payload
//  s_*       | in  | s_tvalid/s_tready | s_tdata[15:0] = sample
//  m_*       | out | m_tvalid/m_tready | m_tdata[6:0] = level, [7] = locked
//  cfg_*     | in  | cfg_wr_en         | cfg_index selects, cfg_wr_data[15:0]
//
// For each sample the sequencer drives one 16x16 multiplier through four products
// (two for the average, two for the level mapping) plus update steps.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; a new sample is taken while it waits,
// and the last step stalls only if that register is still full.
// rst is synchronous and restores the register defaults and the cleared state.
`timescale 1ns / 1ps
`default_nettype none
module ambient_brightness_level_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,   // [15:0] sample
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [7:0]                             m_tdata,   // [6:0] level, [7] locked
  input  wire logic                              cfg_wr_en,
  input  wire logic [abl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [abl_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import abl_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MLO  = 8'b0000_0010,
    ST_MHI  = 8'b0000_0100,
    ST_UPD  = 8'b0000_1000,
    ST_LLO  = 8'b0001_0000,
    ST_LHI  = 8'b0010_0000,
    ST_MAP  = 8'b0100_0000,
    ST_HYST = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ALPHA_W-1:0] alpha;
  logic [BAND_W-1:0]  band;
  logic [TICKS_W-1:0] lock_ticks;

  logic [FILT_W-1:0]  filt;
  logic [LEVEL_W-1:0] cur_level;
  logic               lock_flag;
  logic [TICKS_W-1:0] settle_count;

  logic [FILT_W-1:0]  mag;
  logic               neg;
  logic [Q8_W-1:0]    new8;

  mac_op_t            mac_op;
  logic [15:0]        mac_x;
  logic [15:0]        mac_y;
  logic [ACC_W-1:0]   acc;

  logic               in_xfer;
  logic               advance;
  logic [FILT_W-1:0]  samp_q16;
  logic [FILT_W-1:0]  acc_ceil;
  logic [21:0]        raw8;
  logic [Q8_W-1:0]    cur8;
  logic [Q8_W-1:0]    jump;
  logic               past;
  logic [TICKS_W-1:0] count_inc;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign advance  = (state == ST_HYST) && (!m_tvalid || m_tready);
  assign samp_q16 = {s_tdata, 16'd0};

  abl_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .x   (mac_x),
    .y   (mac_y),
    .acc (acc)
  );

  always_comb begin
    mac_op   = '0;
    mac_x    = mag[15:0];
    mac_y    = alpha;
    acc_ceil = acc[47:16] + FILT_W'(acc[15:0] != 16'd0);
    raw8     = 22'(LEVEL_MIN_Q8) + 22'(acc[38:18]);
    cur8     = {cur_level, 8'd0};
    jump     = (cur8 > new8) ? (cur8 - new8) : (new8 - cur8);
    past     = jump > {band, 8'd0};
    count_inc = (settle_count != SETTLE_MAX) ? settle_count + 8'd1 : settle_count;
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_MLO;
      ST_MLO: begin
        mac_op     = '{en: 1'b1, clear: 1'b1, upper: 1'b0};
        state_next = ST_MHI;
      end
      ST_MHI: begin
        mac_op     = '{en: 1'b1, clear: 1'b0, upper: 1'b1};
        mac_x      = mag[31:16];
        state_next = ST_UPD;
      end
      ST_UPD: state_next = ST_LLO;
      ST_LLO: begin
        mac_op     = '{en: 1'b1, clear: 1'b1, upper: 1'b0};
        mac_x      = filt[15:0];
        mac_y      = LEVEL_SLOPE;
        state_next = ST_LHI;
      end
      ST_LHI: begin
        mac_op     = '{en: 1'b1, clear: 1'b0, upper: 1'b1};
        mac_x      = filt[31:16];
        mac_y      = LEVEL_SLOPE;
        state_next = ST_MAP;
      end
      ST_MAP: state_next = ST_HYST;
      ST_HYST: if (advance) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= ALPHA_RESET;
      band       <= BAND_RESET;
      lock_ticks <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha      <= cfg_wr_data;
        CFG_BAND:  band       <= cfg_wr_data[BAND_W-1:0];
        CFG_TICKS: lock_ticks <= cfg_wr_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // The average moves by floor(alpha*(sample - avg)/2^16); the sign and
  // magnitude of the difference are kept so that the multiplier stays unsigned.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg <= filt > samp_q16;
      mag <= (filt > samp_q16) ? (filt - samp_q16) : (samp_q16 - filt);
    end
    if (state == ST_MAP) begin
      new8 <= (raw8 > 22'(LEVEL_MAX_Q8)) ? LEVEL_MAX_Q8 : raw8[Q8_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt         <= '0;
      cur_level    <= '0;
      lock_flag    <= 1'b0;
      settle_count <= '0;
    end else begin
      if (state == ST_UPD) begin
        // Rounding toward minus infinity: a negative step takes the ceiling.
        filt <= neg ? filt - acc_ceil : filt + acc[47:16];
      end
      if (advance) begin
        if (past) begin
          lock_flag    <= 1'b0;
          settle_count <= '0;
          cur_level    <= new8[14:8];
        end else if (!lock_flag) begin
          settle_count <= count_inc;
          if (count_inc > lock_ticks) lock_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata[7] <= past ? 1'b0 : (lock_flag || (count_inc > lock_ticks));
      m_tdata[6:0] <= past ? new8[14:8] : cur_level;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("sample taken while another one is in progress");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] <= 7'd100))
    else $error("level above 100");

  a_q8_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HYST) |-> (new8 >= LEVEL_MIN_Q8 && new8 <= LEVEL_MAX_Q8))
    else $error("mapped level out of clamp range");

  a_move_clears: assert property (@(posedge clk) disable iff (rst)
    advance && past |=> (settle_count == '0) && !lock_flag)
    else $error("move did not clear settle state");

  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    advance && lock_flag && !past |=> lock_flag && $stable(cur_level))
    else $error("locked state changed without a jump");

endmodule
`default_nettype wire
